// File: sv/pump_valve_cycle_sequencer_macros.svh
// ----------------------------------------------------------------------------
// pump valve cycle sequencer assertion macros
// shared concurrent assertion forms for the sequencer checker
// ----------------------------------------------------------------------------
`ifndef PUMP_VALVE_CYCLE_SEQUENCER_MACROS_SVH
`define PUMP_VALVE_CYCLE_SEQUENCER_MACROS_SVH

// same-cycle implication, reset-qualified
`define PVCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset-qualified
`define PVCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pvcs_pkg.sv
// ----------------------------------------------------------------------------
// pvcs_pkg
// widths, register indexes and timing constants of the pump valve sequencer
// ----------------------------------------------------------------------------
package pvcs_pkg;

  localparam int SampleW   = 12;
  localparam int GearW     = 2;
  localparam int CfgIdxW   = 3;
  localparam int FaultCntW = 9;
  localparam int TicksW    = 6;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THR_GEAR_ONE   = 3'd0,
    CFG_THR_GEAR_TWO   = 3'd1,
    CFG_THR_GEAR_THREE = 3'd2,
    CFG_SENSOR_HIGH    = 3'd3,
    CFG_SENSOR_LOW     = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [SampleW-1:0] ThrGearOneRst   = 12'd480;
  localparam logic [SampleW-1:0] ThrGearTwoRst   = 12'd640;
  localparam logic [SampleW-1:0] ThrGearThreeRst = 12'd901;
  localparam logic [SampleW-1:0] SensorHighRst   = 12'd4000;
  localparam logic [SampleW-1:0] SensorLowRst    = 12'd100;

  // gear codes
  localparam logic [GearW-1:0] GearOff = 2'd0;
  localparam logic [GearW-1:0] GearOne = 2'd1;
  localparam logic [GearW-1:0] GearTwo = 2'd2;

  // fault counter drain per in-range sample
  localparam logic [FaultCntW-1:0] FaultDrain = 9'd25;

  // tick counts
  localparam logic [TicksW-1:0] PumpSettle = 6'd4;
  localparam logic [TicksW-1:0] HoldEndOne = 6'd24;  // settle plus 20 hold
  localparam logic [TicksW-1:0] HoldEndTwo = 6'd60;  // settle plus 56 hold
  localparam logic [TicksW-1:0] ValveTicks = 6'd24;

endpackage

// File: sv/pump_valve_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// pump_valve_cycle_sequencer
// four-phase pump and valve sequencer with a leaky sensor fault counter
// ----------------------------------------------------------------------------
// Each input transaction is one control tick carrying a 12-bit pressure
// sample and a gear level, and produces exactly one output transaction with
// the drive states after that tick, the latched sensor fault flag, a
// one-shot fault event and the hold mark. The whole tick update (range
// check, fault counter, phase step) is a short combinational path from the
// state registers into the state and result registers, so one transaction
// is taken on every clock while the result register is free or being
// drained in the same cycle. in_stall_o only rises when a result waits and
// out_stall_i is high. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must do so while the block is idle, as
// the block does not enforce it. Indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module pump_valve_cycle_sequencer #(
  parameter int FAULT_COUNT_LIMIT = 400
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [pvcs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pvcs_pkg::SampleW-1:0] cfg_data_i,
  // input transactions
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pvcs_pkg::SampleW-1:0] pressure_sample_i,
  input  logic [pvcs_pkg::GearW-1:0]   gear_level_i,
  // output transactions
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         pump_drive_o,
  output logic                         vent_valve_drive_o,
  output logic                         valve_s_drive_o,
  output logic                         valve_p_drive_o,
  output logic                         sensor_fault_o,
  output logic                         fault_raised_o,
  output logic                         target_reached_mark_o
);

  localparam logic [pvcs_pkg::FaultCntW-1:0] LimitC = pvcs_pkg::FaultCntW'(FAULT_COUNT_LIMIT);

  // cycle phases
  typedef enum logic [1:0] {
    PH_VENT_PUMP = 2'd0,
    PH_PUMP      = 2'd1,
    PH_VALVE_P   = 2'd2,
    PH_VALVE_S   = 2'd3
  } phase_e;

  // configuration registers
  logic [pvcs_pkg::SampleW-1:0] thr_one_q, thr_two_q, thr_three_q;
  logic [pvcs_pkg::SampleW-1:0] high_lim_q, low_lim_q;

  // tick state
  logic [pvcs_pkg::FaultCntW-1:0] fault_cnt_q, fault_cnt_d;
  logic                           latched_q, latched_d;
  phase_e                         phase_q, phase_d;
  logic [pvcs_pkg::TicksW-1:0]    ticks_q, ticks_d;
  logic                           pump_q, pump_d;
  logic                           vent_q, vent_d;
  logic                           vs_q, vs_d;
  logic                           vp_q, vp_d;

  // result register
  logic out_valid_q;
  logic raised_q, mark_q;

  // combinational tick update
  logic                           raised_d, mark_d;
  logic                           in_accept;
  logic                           out_of_range;
  logic [pvcs_pkg::SampleW-1:0]   threshold;
  logic [pvcs_pkg::FaultCntW-1:0] cnt_inc;
  logic [pvcs_pkg::FaultCntW-1:0] cnt_drain;
  logic [pvcs_pkg::TicksW-1:0]    ticks_inc;
  logic [pvcs_pkg::TicksW-1:0]    hold_end;

  // a new tick is taken whenever the result register is empty or drains now
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_of_range = (pressure_sample_i >= high_lim_q) || (pressure_sample_i <= low_lim_q);
  assign cnt_inc      = fault_cnt_q + 9'd1;
  assign cnt_drain    = (fault_cnt_q >= pvcs_pkg::FaultDrain) ?
                        fault_cnt_q - pvcs_pkg::FaultDrain : '0;
  assign ticks_inc    = ticks_q + 6'd1;
  assign hold_end     = (phase_q == PH_VENT_PUMP) ? pvcs_pkg::HoldEndOne : pvcs_pkg::HoldEndTwo;

  // gear selects the pumping threshold
  always_comb begin
    case (gear_level_i)
      pvcs_pkg::GearOne: threshold = thr_one_q;
      pvcs_pkg::GearTwo: threshold = thr_two_q;
      default:           threshold = thr_three_q;
    endcase
  end

  always_comb begin
    fault_cnt_d = fault_cnt_q;
    latched_d   = latched_q;
    phase_d     = phase_q;
    ticks_d     = ticks_q;
    pump_d      = pump_q;
    vent_d      = vent_q;
    vs_d        = vs_q;
    vp_d        = vp_q;
    raised_d    = 1'b0;
    mark_d      = 1'b0;

    if (gear_level_i == pvcs_pkg::GearOff) begin
      // gear off: everything off, restart the cycle, fault state untouched
      pump_d  = 1'b0;
      vent_d  = 1'b0;
      vs_d    = 1'b0;
      vp_d    = 1'b0;
      ticks_d = '0;
      phase_d = PH_VENT_PUMP;
    end else begin
      // leaky fault counter
      if (out_of_range) begin
        if (cnt_inc >= LimitC) begin
          fault_cnt_d = LimitC;
          if (!latched_q) begin
            latched_d = 1'b1;
            raised_d  = 1'b1;
            pump_d    = 1'b0;
            vent_d    = 1'b0;
            vs_d      = 1'b0;
            vp_d      = 1'b0;
            ticks_d   = '0;
            phase_d   = PH_VENT_PUMP;
          end
        end else begin
          fault_cnt_d = cnt_inc;
        end
      end else begin
        fault_cnt_d = cnt_drain;
        if (cnt_drain == '0) begin
          latched_d = 1'b0;
        end
      end

      // phase step, skipped while the fault is held
      if (!latched_d) begin
        case (phase_q)
          PH_VENT_PUMP, PH_PUMP: begin
            vent_d = (phase_q == PH_VENT_PUMP);
            vs_d   = 1'b1;
            vp_d   = 1'b1;
            if ((pressure_sample_i >= threshold) || (ticks_q >= pvcs_pkg::PumpSettle)) begin
              ticks_d = ticks_inc;
              if (ticks_inc >= pvcs_pkg::PumpSettle) begin
                mark_d = 1'b1;
                pump_d = 1'b0;
                if (ticks_inc >= hold_end) begin
                  ticks_d = '0;
                  phase_d = (phase_q == PH_VENT_PUMP) ? PH_PUMP : PH_VALVE_P;
                end
              end
            end else begin
              pump_d = 1'b1;
            end
          end
          PH_VALVE_P: begin
            vs_d    = 1'b0;
            vp_d    = 1'b1;
            ticks_d = ticks_inc;
            if (ticks_inc >= pvcs_pkg::ValveTicks) begin
              ticks_d = '0;
              phase_d = PH_VALVE_S;
            end
          end
          default: begin
            vs_d    = 1'b1;
            vp_d    = 1'b0;
            ticks_d = ticks_inc;
            if (ticks_inc >= pvcs_pkg::ValveTicks) begin
              ticks_d = '0;
              phase_d = PH_VENT_PUMP;
            end
          end
        endcase
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_one_q   <= pvcs_pkg::ThrGearOneRst;
      thr_two_q   <= pvcs_pkg::ThrGearTwoRst;
      thr_three_q <= pvcs_pkg::ThrGearThreeRst;
      high_lim_q  <= pvcs_pkg::SensorHighRst;
      low_lim_q   <= pvcs_pkg::SensorLowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pvcs_pkg::CFG_THR_GEAR_ONE:   thr_one_q   <= cfg_data_i;
        pvcs_pkg::CFG_THR_GEAR_TWO:   thr_two_q   <= cfg_data_i;
        pvcs_pkg::CFG_THR_GEAR_THREE: thr_three_q <= cfg_data_i;
        pvcs_pkg::CFG_SENSOR_HIGH:    high_lim_q  <= cfg_data_i;
        pvcs_pkg::CFG_SENSOR_LOW:     low_lim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick state, advanced once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_cnt_q <= '0;
      latched_q   <= 1'b0;
      phase_q     <= PH_VENT_PUMP;
      ticks_q     <= '0;
      pump_q      <= 1'b0;
      vent_q      <= 1'b0;
      vs_q        <= 1'b0;
      vp_q        <= 1'b0;
    end else if (in_accept) begin
      fault_cnt_q <= fault_cnt_d;
      latched_q   <= latched_d;
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
      pump_q      <= pump_d;
      vent_q      <= vent_d;
      vs_q        <= vs_d;
      vp_q        <= vp_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // one-shot flags of the result; the drives come straight from the state
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raised_q <= raised_d;
      mark_q   <= mark_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign pump_drive_o          = pump_q;
  assign vent_valve_drive_o    = vent_q;
  assign valve_s_drive_o       = vs_q;
  assign valve_p_drive_o       = vp_q;
  assign sensor_fault_o        = latched_q;
  assign fault_raised_o        = raised_q;
  assign target_reached_mark_o = mark_q;

endmodule

// File: sv/pvcs_checker.sv
// ----------------------------------------------------------------------------
// pvcs_checker
// port-level checks of the pump valve cycle sequencer
// ----------------------------------------------------------------------------
`include "pump_valve_cycle_sequencer_macros.svh"

module pvcs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [pvcs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [pvcs_pkg::SampleW-1:0] cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [pvcs_pkg::SampleW-1:0] pressure_sample_i,
  input logic [pvcs_pkg::GearW-1:0]   gear_level_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         pump_drive_o,
  input logic                         vent_valve_drive_o,
  input logic                         valve_s_drive_o,
  input logic                         valve_p_drive_o,
  input logic                         sensor_fault_o,
  input logic                         fault_raised_o,
  input logic                         target_reached_mark_o
);

  logic drives_off;
  assign drives_off = !pump_drive_o && !vent_valve_drive_o && !valve_s_drive_o &&
                      !valve_p_drive_o;

  // a stalled result holds its payload
  `PVCS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable({pump_drive_o, vent_valve_drive_o, valve_s_drive_o, valve_p_drive_o, sensor_fault_o, fault_raised_o, target_reached_mark_o}), "stalled result changed")

  // the input side only stalls behind a waiting result
  `PVCS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a blocked result")

  // every accepted transaction yields a result on the next cycle
  `PVCS_ASSERT_NXT(a_result_follows, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o, "accepted transaction gave no result")

  // a held fault keeps all drives off and no hold mark
  `PVCS_ASSERT_IMP(a_fault_safe, clk_i, rst_ni, out_valid_o && sensor_fault_o, drives_off && !target_reached_mark_o, "drive active while fault held")

  // the fault event only comes with the flag set
  `PVCS_ASSERT_IMP(a_raise_flag, clk_i, rst_ni, out_valid_o && fault_raised_o, sensor_fault_o, "fault event without fault flag")

endmodule

bind pump_valve_cycle_sequencer pvcs_checker u_pvcs_checker (.*);
